FILE: hw/rtl/sdff_pkg.sv
// Shared constants, types and codes for the signed decimal field formatter.
package sdff_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int MAX_FIELD  = 62;

  localparam int DIG_AW     = $clog2(MAX_DIGITS);
  localparam int DIG_CW     = $clog2(MAX_DIGITS + 1);
  localparam int LEN_W      = $clog2(MAX_FIELD + 2);

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int WIDTH_W    = 6;
  localparam int PREC_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [2*VALUE_W-1:0] RECIP10 = 64'h0000_0000_CCCC_CCCD;
  localparam int                   RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGITS,
    ST_SETUP,
    ST_EMIT
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_WIDTH  = 3'd0,
    REG_PRECISION    = 3'd1,
    REG_LEFT_JUSTIFY = 3'd2,
    REG_HAS_DOT      = 3'd3,
    REG_ZERO_PAD     = 3'd4,
    REG_FORCE_PLUS   = 3'd5,
    REG_SPACE_SIGN   = 3'd6
  } cfg_reg_t;

endpackage

FILE: hw/rtl/sdff_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sdff_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/signed_decimal_field_formatter_unit.sv
// Top level of the signed decimal field formatter (printf %d conversion).
//
//  Channel  Direction  Handshake                   Payload
//  in_      slave      in_tvalid / in_tready        in_tdata: value (32 bit signed)
//  out_     master     out_tvalid / out_tready      out_tdata: char_code, out_tlast
//  cfg_     slave      cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A value yields one decimal digit per cycle (1 to 10) in the divide-by-ten loop,
// then a setup state, then one character per cycle while out_tready stays high.
// Characters pass a fetch stage that reads the digit RAM, then the output register.
// A new request is taken once the last character has been fetched.
// Reset sets the sequencer, valid flags, position and configuration registers;
// the digit RAM is not cleared because every digit is written before it is read.
module signed_decimal_field_formatter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sdff_pkg::VALUE_W-1:0]       in_tdata,    // [31:0] value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sdff_pkg::CHAR_W-1:0]        out_tdata,   // [7:0] char_code
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sdff_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sdff_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import sdff_pkg::*;

  state_t state_r, state_nxt;

  logic [WIDTH_W-1:0] field_width_r;
  logic [PREC_W-1:0]  precision_r;
  logic               left_justify_r, has_dot_r, zero_pad_r, force_plus_r, space_sign_r;

  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic               zero_r, zero_nxt;
  logic               has_sign_r, has_sign_nxt;
  logic [CHAR_W-1:0]  sign_char_r, sign_char_nxt;
  logic [DIG_CW-1:0]  ndig_r, ndig_nxt;

  logic [LEN_W-1:0]   pos_r, pos_nxt;
  logic [LEN_W-1:0]   total_r, total_nxt;
  logic [LEN_W-1:0]   sign_pos_r, sign_pos_nxt;
  logic [LEN_W-1:0]   ds_r, ds_nxt;
  logic [LEN_W-1:0]   de_r, de_nxt;
  logic [CHAR_W-1:0]  pad_char_r, pad_char_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_ram_r, s1_ram_nxt;
  logic [CHAR_W-1:0]  s1_char_r, s1_char_nxt;
  logic               s1_last_r, s1_last_nxt;
  logic               s1_adv;

  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_acc;
  logic               issue;
  logic               ram_we;
  logic               ram_re;
  logic [DIG_AW-1:0]  ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   rem;
  logic                 digits_done;

  logic [WIDTH_W-1:0] prec_mag;
  logic [LEN_W-1:0]   prec_sat, width_sat, ndig_len, dlen, slen, body, blank;
  logic               zero_dot;
  logic               mode_zero_fill;

  logic               in_digits, use_ram, is_sign, is_last;
  logic [LEN_W-1:0]   rdig;
  logic [CHAR_W-1:0]  char_now;

  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_tready);

  // Divide by ten through a reciprocal multiply.
  assign prod        = {{VALUE_W{1'b0}}, mag_r} * RECIP10;
  assign quot        = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
  assign rem         = mag_r - ((quot << 3) + (quot << 1));
  assign digits_done = (quot == '0) || (ndig_r == DIG_CW'(MAX_DIGITS - 1));

  // Layout of the text.
  assign prec_mag  = precision_r[PREC_W-2:0];
  assign prec_sat  = precision_r[PREC_W-1] ? '0 :
                     (prec_mag > WIDTH_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : LEN_W'(prec_mag);
  assign width_sat = (field_width_r > WIDTH_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD)
                                                            : LEN_W'(field_width_r);
  assign ndig_len  = LEN_W'(ndig_r);
  assign zero_dot  = zero_r && has_dot_r && ((precision_r == '1) || (precision_r == '0));
  assign dlen      = zero_dot ? '0 : ((prec_sat > ndig_len) ? prec_sat : ndig_len);
  assign slen      = LEN_W'(has_sign_r);
  assign body      = dlen + slen;
  assign blank     = (width_sat > body) ? (width_sat - body) : '0;
  assign mode_zero_fill = !left_justify_r && !has_dot_r && zero_pad_r;

  // Character at the current position.
  assign in_digits = (pos_r >= ds_r) && (pos_r < de_r);
  assign rdig      = de_r - LEN_W'(1) - pos_r;
  assign use_ram   = in_digits && (rdig < ndig_len);
  assign is_sign   = has_sign_r && (pos_r == sign_pos_r);
  assign is_last   = (pos_r == total_r - LEN_W'(1));
  assign char_now  = is_sign ? sign_char_r : (in_digits ? CH_ZERO : pad_char_r);
  assign ram_raddr = DIG_AW'(rdig);
  assign ram_re    = issue && use_ram;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (digits_done) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ((blank + body) == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (issue && is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    ram_we    = 1'b0;
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_DIGITS: ram_we    = 1'b1;
      ST_SETUP:  ;
      ST_EMIT:   issue     = !s1_valid_r || s1_adv;
      default:   ;
    endcase
  end

  always_comb begin
    mag_nxt       = mag_r;
    zero_nxt      = zero_r;
    has_sign_nxt  = has_sign_r;
    sign_char_nxt = sign_char_r;
    ndig_nxt      = ndig_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    sign_pos_nxt  = sign_pos_r;
    ds_nxt        = ds_r;
    de_nxt        = de_r;
    pad_char_nxt  = pad_char_r;

    if (in_acc) begin
      mag_nxt       = in_tdata[VALUE_W-1] ? (~in_tdata + VALUE_W'(1)) : in_tdata;
      zero_nxt      = (in_tdata == '0);
      has_sign_nxt  = in_tdata[VALUE_W-1] || force_plus_r || space_sign_r;
      sign_char_nxt = in_tdata[VALUE_W-1] ? CH_MINUS : (force_plus_r ? CH_PLUS : CH_SPACE);
      ndig_nxt      = '0;
    end

    if (state_r == ST_DIGITS) begin
      mag_nxt  = quot;
      ndig_nxt = ndig_r + DIG_CW'(1);
    end

    if (state_r == ST_SETUP) begin
      pos_nxt      = '0;
      total_nxt    = blank + body;
      pad_char_nxt = mode_zero_fill ? CH_ZERO : CH_SPACE;
      if (left_justify_r) begin
        sign_pos_nxt = '0;
        ds_nxt       = slen;
      end else if (mode_zero_fill) begin
        sign_pos_nxt = '0;
        ds_nxt       = slen + blank;
      end else begin
        sign_pos_nxt = blank;
        ds_nxt       = blank + slen;
      end
      de_nxt = ds_nxt + dlen;
    end

    if (issue) begin
      pos_nxt = pos_r + LEN_W'(1);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_ram_nxt   = s1_ram_r;
    s1_char_nxt  = s1_char_r;
    s1_last_nxt  = s1_last_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (issue) begin
      s1_valid_nxt = 1'b1;
      s1_ram_nxt   = use_ram;
      s1_char_nxt  = char_now;
      s1_last_nxt  = is_last;
    end

    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = s1_ram_r ? (CH_ZERO + CHAR_W'(ram_rdata)) : s1_char_r;
      out_last_nxt  = s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      pos_r          <= '0;
      field_width_r  <= '0;
      precision_r    <= '1;
      left_justify_r <= 1'b0;
      has_dot_r      <= 1'b0;
      zero_pad_r     <= 1'b0;
      force_plus_r   <= 1'b0;
      space_sign_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIELD_WIDTH:  field_width_r  <= cfg_data[WIDTH_W-1:0];
          REG_PRECISION:    precision_r    <= cfg_data[PREC_W-1:0];
          REG_LEFT_JUSTIFY: left_justify_r <= cfg_data[0];
          REG_HAS_DOT:      has_dot_r      <= cfg_data[0];
          REG_ZERO_PAD:     zero_pad_r     <= cfg_data[0];
          REG_FORCE_PLUS:   force_plus_r   <= cfg_data[0];
          REG_SPACE_SIGN:   space_sign_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    zero_r      <= zero_nxt;
    has_sign_r  <= has_sign_nxt;
    sign_char_r <= sign_char_nxt;
    ndig_r      <= ndig_nxt;
    total_r     <= total_nxt;
    sign_pos_r  <= sign_pos_nxt;
    ds_r        <= ds_nxt;
    de_r        <= de_nxt;
    pad_char_r  <= pad_char_nxt;
    s1_ram_r    <= s1_ram_nxt;
    s1_char_r   <= s1_char_nxt;
    s1_last_r   <= s1_last_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  sdff_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ndig_r[DIG_AW-1:0]),
    .wdata (rem[DIGIT_W-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_accept_starts_digits: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_DIGITS))
    else $error("accepted request did not start the digit loop");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (pos_r < total_r))
    else $error("character position ran past the text length");

  a_stall_holds_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ram_r && !s1_adv) |=> $stable(ram_rdata))
    else $error("digit read data changed under a stalled fetch stage");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && is_last) |=> (state_r == ST_IDLE))
    else $error("sequencer kept running after the final character");

endmodule
